// ----- sv/bsp_pkg.sv -----
`default_nettype none

package bsp_pkg;

    localparam int MAX_SEGS  = 64;
    localparam int SEG_AW    = $clog2(MAX_SEGS);
    localparam int CNT_W     = $clog2(MAX_SEGS + 1);

    localparam int COORD_W   = 32;
    localparam int DELTA_W   = COORD_W + 1;
    localparam int MUL_W     = 35;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int SIDE_W    = 68;
    localparam int SQ_W      = 68;
    localparam int SQ_ITER   = SQ_W / 2;
    localparam int ROOT_W    = SQ_W / 2;
    localparam int REM_W     = ROOT_W + 2;
    localparam int LEN_W     = 32;
    localparam int LO_W      = 34;
    localparam int LPROD_W   = LEN_W + LO_W;
    localparam int WIDE_W    = LPROD_W + LO_W;
    localparam int LIM_SHIFT = 17;

    localparam int SW_W      = 8;
    localparam logic [SW_W-1:0] SW_RESET = 8'd17;
    localparam int COST_W    = SW_W + CNT_W + 1;
    localparam int DIF_W     = CNT_W + 2;
    localparam int IDX_W     = 6;
    localparam int OCOST_W   = 16;
    localparam int TDATA_IN_W  = 4 * COORD_W;
    localparam int TDATA_OUT_W = 24;

    localparam logic [SIDE_W-1:0] NEAR_EPS = SIDE_W'(429496);

    typedef struct packed {
        logic                      diag;
        logic [LEN_W-1:0]          len;
        logic signed [COORD_W-1:0] ey;
        logic signed [COORD_W-1:0] ex;
        logic signed [COORD_W-1:0] sy;
        logic signed [COORD_W-1:0] sx;
    } seg_rec_t;

    localparam int REC_W = $bits(seg_rec_t);

    typedef enum logic [1:0] {
        CLS_RIGHT,
        CLS_LEFT,
        CLS_SPLIT
    } cls_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LD_DIFF,
        ST_LD_SQ0,
        ST_LD_SQ1,
        ST_LD_SQ2,
        ST_LD_ROOT,
        ST_LD_WR,
        ST_S_INIT,
        ST_P_RD,
        ST_P_LAT,
        ST_C_RD,
        ST_C_LAT,
        ST_A0,
        ST_A1,
        ST_B0,
        ST_B1,
        ST_D0,
        ST_D1,
        ST_E0,
        ST_L0,
        ST_L1,
        ST_L2,
        ST_L3,
        ST_L4,
        ST_K,
        ST_P_END,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ----- sv/bsp_partition_selector.sv -----
// a stored segment passes LD_DIFF, LD_SQ0, LD_SQ1, LD_SQ2, LD_ROOT and LD_WR
// after accept, LD_ROOT waiting on the 34-step bit-serial square root for the
// length; a segment with tlast then starts the search, which waits in DONE while
// the result is stalled: each partition/segment pair is scored on the one
// shared multiplier; one item at a time: s_axis_tready is high only while idle
// reset: rst_n clears the count, sequencer and output valid; sets sw_reg to 17
`default_nettype none

module bsp_partition_selector (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // start_x, start_y, end_x, end_y
    input  wire logic [bsp_pkg::TDATA_IN_W-1:0]        s_axis_tdata,
    // diagonal
    input  wire logic                                  s_axis_tuser,
    input  wire logic                                  s_axis_tlast,
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // best_index, best_cost, zero pad
    output logic      [bsp_pkg::TDATA_OUT_W-1:0]       m_axis_tdata,
    // used_fallback
    output logic                                       m_axis_tuser,
    input  wire logic                                  cfg_we,
    input  wire logic [bsp_pkg::SW_W-1:0]              cfg_wdata
);

    localparam int CW = bsp_pkg::COORD_W;
    localparam int DW = bsp_pkg::DELTA_W;
    localparam int SW = bsp_pkg::SIDE_W;

    bsp_pkg::state_t state_reg, state_next;

    logic [bsp_pkg::CNT_W-1:0]  count_reg;
    logic [bsp_pkg::SW_W-1:0]   sw_reg;
    logic                       m_valid_reg;
    logic [bsp_pkg::TDATA_OUT_W-1:0] m_data_reg;
    logic                       m_user_reg;

    logic signed [CW-1:0] in_sx_reg, in_sy_reg, in_ex_reg, in_ey_reg;
    logic                 in_diag_reg, in_last_reg;
    logic signed [DW-1:0] dx_reg, dy_reg;
    logic [bsp_pkg::SQ_W-1:0] sq_reg;

    logic [bsp_pkg::SEG_AW-1:0] p_reg, c_reg, best_idx_reg;
    logic signed [CW-1:0] psx_reg, psy_reg;
    logic signed [DW-1:0] pdx_reg, pdy_reg;
    logic signed [DW-1:0] ux_reg, uy_reg, vx_reg, vy_reg, cdx_reg, cdy_reg;
    logic [bsp_pkg::LEN_W-1:0] clen_reg;

    logic signed [SW-1:0] a_reg, b_reg, dot_reg;
    logic [SW-1:0]        aa_reg, bb_reg;
    logic [bsp_pkg::WIDE_W-1:0] lim_reg, la_reg, lb_reg;

    logic [bsp_pkg::COST_W-1:0] cost_reg, best_cost_reg;
    logic [bsp_pkg::CNT_W-1:0]  left_reg, split_reg;
    logic                       found_reg;

    logic signed [bsp_pkg::MUL_W-1:0]  mul_a, mul_b;
    logic signed [bsp_pkg::PROD_W-1:0] mul_p;
    logic signed [SW-1:0]              mul_side;

    logic                       ram_we, ram_re;
    logic [bsp_pkg::SEG_AW-1:0] ram_raddr;
    bsp_pkg::seg_rec_t          wrec, rrec;

    logic                       sqrt_start, sqrt_done;
    logic [bsp_pkg::SQ_W-1:0]   sqrt_rad;
    logic [bsp_pkg::ROOT_W-1:0] sqrt_root;

    logic s_accept, result_load, c_last, p_last;

    bsp_pkg::cls_t cls;
    logic a_neg, b_neg, a_pos, b_pos, near_a, near_b, dot_neg;

    logic signed [bsp_pkg::DIF_W-1:0] diff;
    logic [bsp_pkg::DIF_W-1:0]        adiff;
    logic                             qualify, better;
    logic [bsp_pkg::COST_W-1:0]       cost_new;
    logic [bsp_pkg::OCOST_W-1:0]      ocost;
    logic [bsp_pkg::IDX_W-1:0]        oidx;

    bsp_ram #(
        .WIDTH (bsp_pkg::REC_W),
        .DEPTH (bsp_pkg::MAX_SEGS)
    ) u_seg_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[bsp_pkg::SEG_AW-1:0]),
        .wdata (wrec),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rrec)
    );

    bsp_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    bsp_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .rad   (sqrt_rad),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    assign s_accept    = s_axis_tvalid && s_axis_tready;
    assign result_load = (state_reg == bsp_pkg::ST_DONE) && (!m_valid_reg || m_axis_tready);
    assign c_last = (bsp_pkg::CNT_W'(c_reg) == count_reg - bsp_pkg::CNT_W'(1));
    assign p_last = (bsp_pkg::CNT_W'(p_reg) == count_reg - bsp_pkg::CNT_W'(1));
    assign mul_side = mul_p[SW-1:0];
    assign sqrt_rad = sq_reg + mul_p[bsp_pkg::SQ_W-1:0];

    always_comb
    begin
        wrec.diag = in_diag_reg;
        wrec.len  = (|sqrt_root[bsp_pkg::ROOT_W-1:bsp_pkg::LEN_W]) ? '1
                  : sqrt_root[bsp_pkg::LEN_W-1:0];
        wrec.ey   = in_ey_reg;
        wrec.ex   = in_ex_reg;
        wrec.sy   = in_sy_reg;
        wrec.sx   = in_sx_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bsp_pkg::ST_IDLE:
            begin
                if (s_accept)
                begin
                    if (count_reg < bsp_pkg::CNT_W'(bsp_pkg::MAX_SEGS))
                        state_next = bsp_pkg::ST_LD_DIFF;
                    else if (s_axis_tlast)
                        state_next = bsp_pkg::ST_S_INIT;
                end
            end
            bsp_pkg::ST_LD_DIFF: state_next = bsp_pkg::ST_LD_SQ0;
            bsp_pkg::ST_LD_SQ0:  state_next = bsp_pkg::ST_LD_SQ1;
            bsp_pkg::ST_LD_SQ1:  state_next = bsp_pkg::ST_LD_SQ2;
            bsp_pkg::ST_LD_SQ2:  state_next = bsp_pkg::ST_LD_ROOT;
            bsp_pkg::ST_LD_ROOT:
            begin
                if (sqrt_done)
                    state_next = bsp_pkg::ST_LD_WR;
            end
            bsp_pkg::ST_LD_WR:
                state_next = in_last_reg ? bsp_pkg::ST_S_INIT : bsp_pkg::ST_IDLE;
            bsp_pkg::ST_S_INIT:  state_next = bsp_pkg::ST_P_RD;
            bsp_pkg::ST_P_RD:    state_next = bsp_pkg::ST_P_LAT;
            bsp_pkg::ST_P_LAT:   state_next = bsp_pkg::ST_C_RD;
            bsp_pkg::ST_C_RD:    state_next = bsp_pkg::ST_C_LAT;
            bsp_pkg::ST_C_LAT:   state_next = bsp_pkg::ST_A0;
            bsp_pkg::ST_A0:      state_next = bsp_pkg::ST_A1;
            bsp_pkg::ST_A1:      state_next = bsp_pkg::ST_B0;
            bsp_pkg::ST_B0:      state_next = bsp_pkg::ST_B1;
            bsp_pkg::ST_B1:      state_next = bsp_pkg::ST_D0;
            bsp_pkg::ST_D0:      state_next = bsp_pkg::ST_D1;
            bsp_pkg::ST_D1:      state_next = bsp_pkg::ST_E0;
            bsp_pkg::ST_E0:      state_next = bsp_pkg::ST_L0;
            bsp_pkg::ST_L0:      state_next = bsp_pkg::ST_L1;
            bsp_pkg::ST_L1:      state_next = bsp_pkg::ST_L2;
            bsp_pkg::ST_L2:      state_next = bsp_pkg::ST_L3;
            bsp_pkg::ST_L3:      state_next = bsp_pkg::ST_L4;
            bsp_pkg::ST_L4:      state_next = bsp_pkg::ST_K;
            bsp_pkg::ST_K:
                state_next = c_last ? bsp_pkg::ST_P_END : bsp_pkg::ST_C_RD;
            bsp_pkg::ST_P_END:
                state_next = p_last ? bsp_pkg::ST_DONE : bsp_pkg::ST_P_RD;
            bsp_pkg::ST_DONE:
            begin
                if (!m_valid_reg || m_axis_tready)
                    state_next = bsp_pkg::ST_IDLE;
            end
            default: state_next = bsp_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs: multiplier operands, memory and root unit control
    always_comb
    begin
        mul_a         = '0;
        mul_b         = '0;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_raddr     = c_reg;
        sqrt_start    = 1'b0;
        s_axis_tready = 1'b0;
        case (state_reg)
            bsp_pkg::ST_IDLE:   s_axis_tready = 1'b1;
            bsp_pkg::ST_LD_SQ0:
            begin
                mul_a = bsp_pkg::MUL_W'(dx_reg);
                mul_b = bsp_pkg::MUL_W'(dx_reg);
            end
            bsp_pkg::ST_LD_SQ1:
            begin
                mul_a = bsp_pkg::MUL_W'(dy_reg);
                mul_b = bsp_pkg::MUL_W'(dy_reg);
            end
            bsp_pkg::ST_LD_SQ2: sqrt_start = 1'b1;
            bsp_pkg::ST_LD_WR:  ram_we = 1'b1;
            bsp_pkg::ST_P_RD:
            begin
                ram_re    = 1'b1;
                ram_raddr = p_reg;
            end
            bsp_pkg::ST_C_RD:   ram_re = 1'b1;
            bsp_pkg::ST_A0:
            begin
                mul_a = bsp_pkg::MUL_W'(pdy_reg);
                mul_b = bsp_pkg::MUL_W'(ux_reg);
            end
            bsp_pkg::ST_A1:
            begin
                mul_a = bsp_pkg::MUL_W'(pdx_reg);
                mul_b = bsp_pkg::MUL_W'(uy_reg);
            end
            bsp_pkg::ST_B0:
            begin
                mul_a = bsp_pkg::MUL_W'(pdy_reg);
                mul_b = bsp_pkg::MUL_W'(vx_reg);
            end
            bsp_pkg::ST_B1:
            begin
                mul_a = bsp_pkg::MUL_W'(pdx_reg);
                mul_b = bsp_pkg::MUL_W'(vy_reg);
            end
            bsp_pkg::ST_D0:
            begin
                mul_a = bsp_pkg::MUL_W'(cdx_reg);
                mul_b = bsp_pkg::MUL_W'(pdx_reg);
            end
            bsp_pkg::ST_D1:
            begin
                mul_a = bsp_pkg::MUL_W'(cdy_reg);
                mul_b = bsp_pkg::MUL_W'(pdy_reg);
            end
            bsp_pkg::ST_L0:
            begin
                mul_a = $signed(bsp_pkg::MUL_W'(clen_reg));
                mul_b = $signed(bsp_pkg::MUL_W'(aa_reg[bsp_pkg::LO_W-1:0]));
            end
            bsp_pkg::ST_L1:
            begin
                mul_a = $signed(bsp_pkg::MUL_W'(clen_reg));
                mul_b = $signed(bsp_pkg::MUL_W'(aa_reg[SW-1:bsp_pkg::LO_W]));
            end
            bsp_pkg::ST_L2:
            begin
                mul_a = $signed(bsp_pkg::MUL_W'(clen_reg));
                mul_b = $signed(bsp_pkg::MUL_W'(bb_reg[bsp_pkg::LO_W-1:0]));
            end
            bsp_pkg::ST_L3:
            begin
                mul_a = $signed(bsp_pkg::MUL_W'(clen_reg));
                mul_b = $signed(bsp_pkg::MUL_W'(bb_reg[SW-1:bsp_pkg::LO_W]));
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    // side classification of the check segment against the partition line
    always_comb
    begin
        a_neg   = a_reg[SW-1];
        b_neg   = b_reg[SW-1];
        a_pos   = !a_neg && (a_reg != '0);
        b_pos   = !b_neg && (b_reg != '0);
        near_a  = (aa_reg <= bsp_pkg::NEAR_EPS);
        near_b  = (bb_reg <= bsp_pkg::NEAR_EPS);
        dot_neg = dot_reg[SW-1];
        cls     = bsp_pkg::CLS_RIGHT;
        if ((a_neg && b_pos) || (a_pos && b_neg))
        begin
            if (!near_a && !near_b)
            begin
                // crossing at least 2 units past the start is a real split
                if (la_reg >= lim_reg)
                    cls = bsp_pkg::CLS_SPLIT;
                else if (lb_reg < lim_reg)
                    cls = dot_neg ? bsp_pkg::CLS_LEFT : bsp_pkg::CLS_RIGHT;
                else
                    cls = b_neg ? bsp_pkg::CLS_LEFT : bsp_pkg::CLS_RIGHT;
            end
            else
            begin
                cls = bsp_pkg::CLS_LEFT;
            end
        end
        else if (!a_pos && (!near_a || (near_b && dot_neg)))
        begin
            cls = bsp_pkg::CLS_LEFT;
        end
    end

    // partition score once all check segments are classified
    always_comb
    begin
        diff = $signed(bsp_pkg::DIF_W'(count_reg))
             - $signed(bsp_pkg::DIF_W'({left_reg, 1'b0}))
             - $signed(bsp_pkg::DIF_W'(split_reg));
        adiff    = diff[bsp_pkg::DIF_W-1] ? bsp_pkg::DIF_W'(-diff) : bsp_pkg::DIF_W'(diff);
        qualify  = (bsp_pkg::DIF_W'(split_reg) + bsp_pkg::DIF_W'(count_reg)) > adiff;
        cost_new = cost_reg + bsp_pkg::COST_W'(adiff);
        better   = qualify && (!found_reg || (cost_new < best_cost_reg));
        ocost    = (32'(best_cost_reg) > 32'd65535) ? '1
                 : bsp_pkg::OCOST_W'(best_cost_reg);
        oidx     = bsp_pkg::IDX_W'(best_idx_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= bsp_pkg::ST_IDLE;
            count_reg   <= '0;
            sw_reg      <= bsp_pkg::SW_RESET;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                sw_reg <= cfg_wdata;
            if (state_reg == bsp_pkg::ST_LD_WR)
                count_reg <= count_reg + 1'b1;
            else if (result_load)
                count_reg <= '0;
            if (result_load)
                m_valid_reg <= 1'b1;
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            m_data_reg <= {{(bsp_pkg::TDATA_OUT_W - bsp_pkg::OCOST_W - bsp_pkg::IDX_W){1'b0}},
                           found_reg ? ocost : {bsp_pkg::OCOST_W{1'b1}},
                           found_reg ? oidx : {bsp_pkg::IDX_W{1'b0}}};
            m_user_reg <= !found_reg;
        end
        case (state_reg)
            bsp_pkg::ST_IDLE:
            begin
                if (s_accept)
                begin
                    in_sx_reg   <= s_axis_tdata[CW-1:0];
                    in_sy_reg   <= s_axis_tdata[2*CW-1:CW];
                    in_ex_reg   <= s_axis_tdata[3*CW-1:2*CW];
                    in_ey_reg   <= s_axis_tdata[4*CW-1:3*CW];
                    in_diag_reg <= s_axis_tuser;
                    in_last_reg <= s_axis_tlast;
                end
            end
            bsp_pkg::ST_LD_DIFF:
            begin
                dx_reg <= DW'(in_ex_reg) - DW'(in_sx_reg);
                dy_reg <= DW'(in_ey_reg) - DW'(in_sy_reg);
            end
            bsp_pkg::ST_LD_SQ1:
                sq_reg <= mul_p[bsp_pkg::SQ_W-1:0];
            bsp_pkg::ST_S_INIT:
            begin
                p_reg         <= '0;
                found_reg     <= 1'b0;
                best_cost_reg <= '0;
                best_idx_reg  <= '0;
            end
            bsp_pkg::ST_P_LAT:
            begin
                psx_reg   <= rrec.sx;
                psy_reg   <= rrec.sy;
                pdx_reg   <= DW'(rrec.ex) - DW'(rrec.sx);
                pdy_reg   <= DW'(rrec.ey) - DW'(rrec.sy);
                cost_reg  <= rrec.diag ? bsp_pkg::COST_W'(sw_reg) : '0;
                left_reg  <= '0;
                split_reg <= '0;
                c_reg     <= '0;
            end
            bsp_pkg::ST_C_LAT:
            begin
                ux_reg   <= DW'(rrec.sx) - DW'(psx_reg);
                uy_reg   <= DW'(rrec.sy) - DW'(psy_reg);
                vx_reg   <= DW'(rrec.ex) - DW'(psx_reg);
                vy_reg   <= DW'(rrec.ey) - DW'(psy_reg);
                cdx_reg  <= DW'(rrec.ex) - DW'(rrec.sx);
                cdy_reg  <= DW'(rrec.ey) - DW'(rrec.sy);
                clen_reg <= rrec.len;
            end
            bsp_pkg::ST_A1: a_reg   <= mul_side;
            bsp_pkg::ST_B0: a_reg   <= a_reg - mul_side;
            bsp_pkg::ST_B1: b_reg   <= mul_side;
            bsp_pkg::ST_D0: b_reg   <= b_reg - mul_side;
            bsp_pkg::ST_D1: dot_reg <= mul_side;
            bsp_pkg::ST_E0:
            begin
                dot_reg <= dot_reg + mul_side;
                aa_reg  <= a_reg[SW-1] ? SW'(-a_reg) : SW'(a_reg);
                bb_reg  <= b_reg[SW-1] ? SW'(-b_reg) : SW'(b_reg);
            end
            bsp_pkg::ST_L0:
                lim_reg <= bsp_pkg::WIDE_W'({(SW+1)'(aa_reg) + (SW+1)'(bb_reg),
                                             {bsp_pkg::LIM_SHIFT{1'b0}}});
            bsp_pkg::ST_L1:
                la_reg <= bsp_pkg::WIDE_W'(mul_p[bsp_pkg::LPROD_W-1:0]);
            bsp_pkg::ST_L2:
                la_reg <= la_reg + bsp_pkg::WIDE_W'({mul_p[bsp_pkg::LPROD_W-1:0],
                                                     {bsp_pkg::LO_W{1'b0}}});
            bsp_pkg::ST_L3:
                lb_reg <= bsp_pkg::WIDE_W'(mul_p[bsp_pkg::LPROD_W-1:0]);
            bsp_pkg::ST_L4:
                lb_reg <= lb_reg + bsp_pkg::WIDE_W'({mul_p[bsp_pkg::LPROD_W-1:0],
                                                     {bsp_pkg::LO_W{1'b0}}});
            bsp_pkg::ST_K:
            begin
                if (cls == bsp_pkg::CLS_SPLIT)
                begin
                    cost_reg  <= cost_reg + bsp_pkg::COST_W'(sw_reg);
                    split_reg <= split_reg + 1'b1;
                end
                else if (cls == bsp_pkg::CLS_LEFT)
                begin
                    left_reg <= left_reg + 1'b1;
                end
                c_reg <= c_reg + 1'b1;
            end
            bsp_pkg::ST_P_END:
            begin
                if (better)
                begin
                    found_reg     <= 1'b1;
                    best_cost_reg <= cost_new;
                    best_idx_reg  <= p_reg;
                end
                p_reg <= p_reg + 1'b1;
            end
            default:
            begin
                sq_reg <= sq_reg;
            end
        endcase
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule

`default_nettype wire

// ----- sv/bsp_ram.sv -----
`default_nettype none

module bsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- sv/bsp_mul.sv -----
`default_nettype none

module bsp_mul (
    input  wire logic                               clk,
    input  wire logic signed [bsp_pkg::MUL_W-1:0]   a,
    input  wire logic signed [bsp_pkg::MUL_W-1:0]   b,
    output logic signed      [bsp_pkg::PROD_W-1:0]  p
);

    logic signed [bsp_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign p = prod_reg;

endmodule

`default_nettype wire

// ----- sv/bsp_isqrt.sv -----
`default_nettype none

module bsp_isqrt (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [bsp_pkg::SQ_W-1:0]    rad,
    output logic                             done,
    output logic      [bsp_pkg::ROOT_W-1:0]  root
);

    localparam int IT_W = $clog2(bsp_pkg::SQ_ITER);

    logic [bsp_pkg::SQ_W-1:0]   rad_reg;
    logic [bsp_pkg::REM_W-1:0]  rem_reg;
    logic [bsp_pkg::ROOT_W-1:0] root_reg;
    logic [IT_W-1:0]            it_reg;
    logic                       busy_reg;
    logic                       done_reg;

    logic [bsp_pkg::REM_W-1:0]  rem_sh;
    logic [bsp_pkg::REM_W-1:0]  trial;
    logic                       take;

    // one result bit per cycle, restoring digit method
    assign rem_sh = {rem_reg[bsp_pkg::REM_W-3:0], rad_reg[bsp_pkg::SQ_W-1 -: 2]};
    assign trial  = {root_reg, 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && (it_reg == '0))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= rad;
            rem_reg  <= '0;
            root_reg <= '0;
            it_reg   <= IT_W'(bsp_pkg::SQ_ITER - 1);
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[bsp_pkg::SQ_W-3:0], 2'b00};
            rem_reg  <= take ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[bsp_pkg::ROOT_W-2:0], take};
            it_reg   <= it_reg - 1'b1;
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

// ----- sv/bsp_checker.sv -----
`default_nettype none

module bsp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata,
    input wire logic        m_axis_tuser
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result item changed while stalled");

    // fallback answer is index 0 at saturated cost
    a_fallback: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[21:0] == {16'hFFFF, 6'd0})
        else $error("fallback item with wrong index or cost");

    // a result only appears after a busy search
    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result item appeared while input side was idle");

    // the edge that sees reset has cleared the output valid by the next edge
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("result valid during reset");

endmodule

bind bsp_partition_selector bsp_checker u_bsp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
